// ----- hw/rtl/sbbpt_pkg.sv -----
// ----------------------------------------------------------------------------
// sbbpt_pkg
// Types and constants shared by the servo bus packet tracker modules.
// ----------------------------------------------------------------------------
package sbbpt_pkg;

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_SYNC1     = 4'd1;
    localparam logic [3:0] PH_SYNC2     = 4'd2;
    localparam logic [3:0] PH_SHORT_LEN = 4'd3;
    localparam logic [3:0] PH_RSVD      = 4'd4;
    localparam logic [3:0] PH_LONG_ID   = 4'd5;
    localparam logic [3:0] PH_LONG_LO   = 4'd6;
    localparam logic [3:0] PH_LONG_HI   = 4'd7;
    localparam logic [3:0] PH_FIRST     = 4'd8;
    localparam logic [3:0] PH_BODY      = 4'd9;

    localparam logic [1:0] FMT_NONE  = 2'd0;
    localparam logic [1:0] FMT_SHORT = 2'd1;
    localparam logic [1:0] FMT_LONG  = 2'd2;

    localparam logic [7:0] SYNC_BYTE         = 8'hFF;
    localparam logic [7:0] LONG_MARK         = 8'hFD;
    localparam logic [7:0] SUM_GOOD          = 8'hFF;
    localparam logic [7:0] INSTR_BULK_READ   = 8'h92;
    localparam logic [7:0] INSTR_BULK_STATUS = 8'h12;
    localparam logic [7:0] BULK_READ_OVERHD  = 8'd3;
    localparam logic [1:0] STATUS_SKIP       = 2'd2;

    typedef struct packed {
        logic       counted;
        logic       first;
        logic       frame_end;
        logic       sum_bad;
        logic [1:0] format;
        logic [7:0] len_lo;
    } t_frm_status;

    // floor(x / 3) for 8-bit x by reciprocal multiply
    function automatic logic [7:0] div3(input logic [7:0] x);
        logic [15:0] prod;
        prod = {8'd0, x} * 16'd171;
        return {1'b0, prod[15:9]};
    endfunction

endpackage

// ----- hw/rtl/sbbpt_framer.sv -----
// ----------------------------------------------------------------------------
// sbbpt_framer
// Per-port packet framer: sync search, short/long header, payload count
// and short-format checksum.
// ----------------------------------------------------------------------------
module sbbpt_framer
    import sbbpt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [7:0]  i_byte,
    output t_frm_status o_status
);

    logic [3:0]  r_phase, n_phase;
    logic [1:0]  r_format, n_format;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_rem, n_rem;
    logic        counted;
    logic        first;
    logic        frame_end;

    always_comb begin
        n_phase   = r_phase;
        n_format  = r_format;
        n_sum     = r_sum;
        n_rem     = r_rem;
        counted   = 1'b0;
        first     = 1'b0;
        frame_end = 1'b0;
        unique case (r_phase)
            PH_SYNC1: begin
                n_phase = (i_byte == SYNC_BYTE) ? PH_SYNC2 : PH_IDLE;
            end
            PH_SYNC2: begin
                if (i_byte == LONG_MARK) begin
                    n_phase  = PH_RSVD;
                    n_format = FMT_LONG;
                end else begin
                    n_phase  = PH_SHORT_LEN;
                    n_format = FMT_SHORT;
                    n_sum    = i_byte;
                end
            end
            PH_SHORT_LEN: begin
                n_phase = PH_FIRST;
                n_rem   = {8'd0, i_byte};
                n_sum   = r_sum + i_byte;
            end
            PH_RSVD: begin
                n_phase = PH_LONG_ID;
            end
            PH_LONG_ID: begin
                n_phase = PH_LONG_LO;
            end
            PH_LONG_LO: begin
                n_phase = PH_LONG_HI;
                n_rem   = {8'd0, i_byte};
            end
            PH_LONG_HI: begin
                n_phase = PH_FIRST;
                n_rem   = {i_byte, r_rem[7:0]};
            end
            PH_FIRST: begin
                n_phase = PH_BODY;
                counted = 1'b1;
                first   = 1'b1;
            end
            PH_BODY: begin
                counted = 1'b1;
            end
            default: begin
                n_phase = (i_byte == SYNC_BYTE) ? PH_SYNC1 : PH_IDLE;
            end
        endcase
        if (counted) begin
            n_sum = r_sum + i_byte;
            n_rem = r_rem - 16'd1;
            if (n_rem == 16'd0) begin
                n_phase   = PH_IDLE;
                frame_end = 1'b1;
            end
        end
    end

    always_comb begin
        o_status.counted   = counted;
        o_status.first     = first;
        o_status.frame_end = frame_end;
        o_status.sum_bad   = frame_end && (n_format == FMT_SHORT) && (n_sum != SUM_GOOD);
        o_status.format    = n_format;
        o_status.len_lo    = r_rem[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_format <= FMT_NONE;
            r_sum    <= 8'd0;
            r_rem    <= 16'd0;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_format <= n_format;
            r_sum    <= n_sum;
            r_rem    <= n_rem;
        end
    end

endmodule

// ----- hw/rtl/servo_bus_bridge_packet_tracker.sv -----
// ----------------------------------------------------------------------------
// servo_bus_bridge_packet_tracker
// Two-port servo bus packet tracker with bulk-response counting.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle when the output is not stalled, tagged in tuser
// with its port (0 host command, 1 servo response), and returns exactly one status
// request per byte. Each byte passes an input register and then a result register
// before its status request is presented; the per-port framer state updates as a
// byte moves from the input register to the result register, which sustains one
// byte per cycle while the output is not stalled. tlast on the output marks the byte
// that completes a packet.
module servo_bus_bridge_packet_tracker
    import sbbpt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  logic        i_s_axis_tuser,   // [0] func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [0] sum_bad, [1] returns_complete,
                                          // [9:2] returns_pending,
                                          // [11:10] frame_format, [15:12] zero
    output logic        o_m_axis_tlast,   // frame_end
    output logic        o_m_axis_tuser    // [0] src_port
);

    logic        r_in_valid;
    logic        r_in_func;
    logic [7:0]  r_in_byte;

    logic        r_out_valid;
    logic        r_out_src;
    logic        r_out_last;
    logic        r_out_bad;
    logic        r_out_done;
    logic [7:0]  r_out_pend;
    logic [1:0]  r_out_fmt;

    logic [1:0]  r_countdown, n_countdown;
    logic [7:0]  r_expected, n_expected;
    logic        n_done;

    logic        adv;
    logic        step;
    t_frm_status cmd_st;
    t_frm_status rsp_st;

    assign adv             = !r_out_valid || i_m_axis_tready;
    assign step            = adv && r_in_valid;
    assign o_s_axis_tready = !r_in_valid || adv;

    sbbpt_framer u_cmd_framer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (step && !r_in_func),
        .i_byte   (r_in_byte),
        .o_status (cmd_st)
    );

    sbbpt_framer u_rsp_framer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (step && r_in_func),
        .i_byte   (r_in_byte),
        .o_status (rsp_st)
    );

    always_comb begin
        n_expected  = r_expected;
        n_countdown = r_countdown;
        n_done      = 1'b0;
        if (!r_in_func) begin
            if (cmd_st.first && (cmd_st.format == FMT_SHORT)) begin
                if (r_in_byte == INSTR_BULK_READ) begin
                    n_expected = (cmd_st.len_lo >= BULK_READ_OVERHD)
                        ? div3(cmd_st.len_lo - BULK_READ_OVERHD) : 8'd0;
                end else if (r_in_byte == INSTR_BULK_STATUS) begin
                    n_countdown = STATUS_SKIP;
                end
            end
            if (cmd_st.counted && (n_countdown != 2'd0)) begin
                n_countdown = n_countdown - 2'd1;
                if (n_countdown == 2'd0) begin
                    n_expected = r_in_byte;
                end
            end
        end else if (rsp_st.frame_end) begin
            if (r_expected <= 8'd1) begin
                n_done = 1'b1;
            end else begin
                n_expected = r_expected - 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_countdown <= 2'd0;
            r_expected  <= 8'd0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_countdown <= n_countdown;
                r_expected  <= n_expected;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_func <= i_s_axis_tuser;
            r_in_byte <= i_s_axis_tdata;
        end
        if (step) begin
            r_out_src  <= r_in_func;
            r_out_last <= r_in_func ? rsp_st.frame_end : cmd_st.frame_end;
            r_out_bad  <= r_in_func ? rsp_st.sum_bad : cmd_st.sum_bad;
            r_out_fmt  <= r_in_func ? rsp_st.format : cmd_st.format;
            r_out_done <= n_done;
            r_out_pend <= n_expected;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_out_fmt, r_out_pend, r_out_done, r_out_bad};
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_src;

endmodule
